// File: rtl/clx_pkg.sv
`default_nettype none
// types, constants and character codes of the character stream lexer
package clx_pkg;

  localparam int ChW     = 8;
  localparam int LineW   = 16;
  localparam int EvMax   = 4;
  localparam int EvIdxW  = $clog2(EvMax);
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_INT     = 4'd1,
    ST_DEC     = 4'd2,
    ST_IDENT   = 4'd3,
    ST_STR     = 4'd4,
    ST_DOT     = 4'd5,
    ST_DOTMORE = 4'd6,
    ST_SLASH   = 4'd7,
    ST_CMT     = 4'd8,
    ST_ESC     = 4'd9
  } lex_state_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_DROP   = 2'd2,
    KIND_ERR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    TOK_INT   = 3'd0,
    TOK_DEC   = 3'd1,
    TOK_IDENT = 3'd2,
    TOK_STR   = 3'd3,
    TOK_OP    = 3'd4
  } tok_t;

  localparam logic [ChW-1:0] CH_TAB    = 8'h09;
  localparam logic [ChW-1:0] CH_LF     = 8'h0A;
  localparam logic [ChW-1:0] CH_CR     = 8'h0D;
  localparam logic [ChW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ChW-1:0] CH_QUOTE  = 8'h22;
  localparam logic [ChW-1:0] CH_LPAREN = 8'h28;
  localparam logic [ChW-1:0] CH_RPAREN = 8'h29;
  localparam logic [ChW-1:0] CH_STAR   = 8'h2A;
  localparam logic [ChW-1:0] CH_PLUS   = 8'h2B;
  localparam logic [ChW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [ChW-1:0] CH_MINUS  = 8'h2D;
  localparam logic [ChW-1:0] CH_DOT    = 8'h2E;
  localparam logic [ChW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ChW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ChW-1:0] CH_NINE   = 8'h39;
  localparam logic [ChW-1:0] CH_SEMI   = 8'h3B;
  localparam logic [ChW-1:0] CH_LT     = 8'h3C;
  localparam logic [ChW-1:0] CH_EQ     = 8'h3D;
  localparam logic [ChW-1:0] CH_GT     = 8'h3E;
  localparam logic [ChW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ChW-1:0] CH_LOW_N  = 8'h6E;
  localparam logic [ChW-1:0] CH_LOW_R  = 8'h72;
  localparam logic [ChW-1:0] CH_LOW_T  = 8'h74;
  localparam logic [ChW-1:0] CH_LBRACE = 8'h7B;
  localparam logic [ChW-1:0] CH_PIPE   = 8'h7C;
  localparam logic [ChW-1:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    kind_t          kind;
    logic [ChW-1:0] ch;
    tok_t           tok;
  } lex_event_t;

  // all events caused by one character
  typedef struct packed {
    lex_event_t [EvMax-1:0] ev;
    logic [EvIdxW-1:0]      last_idx;
    logic [LineW-1:0]       line;
  } group_t;

endpackage
`default_nettype wire

// File: rtl/clx_if.sv
`default_nettype none
// valid/ready channel interfaces for characters in and lexer events out
interface clx_in_if;
  logic                     valid;
  logic                     ready;
  logic [clx_pkg::ChW-1:0]  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface clx_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [clx_pkg::ChW-1:0]   ch_out;
  logic [2:0]                tok_type;
  logic [clx_pkg::LineW-1:0] line;
  logic                      last;

  modport source (output valid, output kind, output ch_out, output tok_type,
                  output line, output last, input ready);
  modport sink   (input valid, input kind, input ch_out, input tok_type,
                  input line, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/clx_lexer.sv
`default_nettype none
// input register, lexer state, line counter and per-character event decode
module clx_lexer (
  input  wire logic            clk,
  input  wire logic            rst,
  clx_in_if.sink               in_ch,
  input  wire logic            grp_ready,
  output logic                 push,
  output clx_pkg::group_t      grp
);

  logic                          hold_valid;
  logic [clx_pkg::ChW-1:0]       hold_ch;
  clx_pkg::lex_state_t           lex_state;
  logic [clx_pkg::LineW-1:0]     line_count;

  logic                          adv;
  clx_pkg::lex_state_t           s;
  clx_pkg::lex_state_t           state_next;
  logic                          flush;
  logic                          end_sel;
  logic                          end_has;
  logic                          mid_v;
  logic                          tail_v;
  logic                          line_inc;
  clx_pkg::lex_event_t           end_ev;
  clx_pkg::lex_event_t           mid_ev;
  clx_pkg::lex_event_t           tail_ev;
  clx_pkg::lex_event_t           op_ev;
  clx_pkg::lex_event_t [3:0]     cand;
  logic [3:0]                    cand_v;
  clx_pkg::lex_event_t [clx_pkg::EvMax-1:0] grp_ev;
  logic [clx_pkg::EvIdxW:0]      n;

  assign adv         = hold_valid && grp_ready;
  assign in_ch.ready = !hold_valid || grp_ready;

  // end of the current token
  always_comb begin
    end_has = 1'b1;
    end_ev  = '{kind: clx_pkg::KIND_COMMIT, ch: '0, tok: clx_pkg::TOK_INT};
    unique case (s)
      clx_pkg::ST_INT:     end_ev.tok = clx_pkg::TOK_INT;
      clx_pkg::ST_DEC:     end_ev.tok = clx_pkg::TOK_DEC;
      clx_pkg::ST_IDENT:   end_ev.tok = clx_pkg::TOK_IDENT;
      clx_pkg::ST_STR:     end_ev.tok = clx_pkg::TOK_STR;
      clx_pkg::ST_ESC:     end_ev.tok = clx_pkg::TOK_STR;
      clx_pkg::ST_DOT:     end_ev.tok = clx_pkg::TOK_OP;
      clx_pkg::ST_DOTMORE: end_ev.tok = clx_pkg::TOK_DEC;
      clx_pkg::ST_SLASH:   end_ev.tok = clx_pkg::TOK_OP;
      clx_pkg::ST_CMT:     end_ev.kind = clx_pkg::KIND_DROP;
      default:             end_has = 1'b0;
    endcase
  end

  always_comb begin
    op_ev      = '{kind: clx_pkg::KIND_COMMIT, ch: '0, tok: clx_pkg::TOK_OP};
    s          = lex_state;
    flush      = 1'b0;
    if (lex_state == clx_pkg::ST_SLASH && hold_ch != clx_pkg::CH_SLASH) begin
      flush = 1'b1;
      s     = clx_pkg::ST_IDLE;
    end
    state_next = s;
    end_sel    = 1'b0;
    mid_v      = 1'b0;
    mid_ev     = '{kind: clx_pkg::KIND_APPEND, ch: hold_ch, tok: clx_pkg::TOK_INT};
    tail_v     = 1'b0;
    tail_ev    = op_ev;
    line_inc   = 1'b0;

    if (s == clx_pkg::ST_ESC) begin
      mid_v      = 1'b1;
      state_next = clx_pkg::ST_STR;
      case (hold_ch)
        clx_pkg::CH_LOW_N:  mid_ev.ch = clx_pkg::CH_LF;
        clx_pkg::CH_LOW_R:  mid_ev.ch = clx_pkg::CH_CR;
        clx_pkg::CH_LOW_T:  mid_ev.ch = clx_pkg::CH_TAB;
        clx_pkg::CH_BSLASH: mid_ev.ch = clx_pkg::CH_BSLASH;
        default:            mid_ev.kind = clx_pkg::KIND_ERR;
      endcase
    end else begin
      case (hold_ch) inside
        [clx_pkg::CH_ZERO:clx_pkg::CH_NINE]: begin
          mid_v = 1'b1;
          if (s == clx_pkg::ST_IDLE) begin
            state_next = clx_pkg::ST_INT;
          end else if (s == clx_pkg::ST_DOT || s == clx_pkg::ST_DOTMORE) begin
            state_next = clx_pkg::ST_DEC;
          end
        end
        clx_pkg::CH_DOT: begin
          mid_v = 1'b1;
          if (s == clx_pkg::ST_IDLE) begin
            state_next = clx_pkg::ST_DOT;
          end else if (s == clx_pkg::ST_INT) begin
            state_next = clx_pkg::ST_DEC;
          end else if (s != clx_pkg::ST_STR) begin
            end_sel    = 1'b1;
            tail_v     = 1'b1;
            state_next = clx_pkg::ST_IDLE;
          end
        end
        clx_pkg::CH_LBRACE, clx_pkg::CH_RBRACE, clx_pkg::CH_LPAREN,
        clx_pkg::CH_RPAREN, clx_pkg::CH_EQ, clx_pkg::CH_PLUS, clx_pkg::CH_MINUS,
        clx_pkg::CH_STAR, clx_pkg::CH_GT, clx_pkg::CH_LT, clx_pkg::CH_SEMI,
        clx_pkg::CH_COMMA, clx_pkg::CH_PIPE: begin
          mid_v = 1'b1;
          if (s != clx_pkg::ST_STR) begin
            end_sel    = 1'b1;
            tail_v     = 1'b1;
            state_next = clx_pkg::ST_IDLE;
          end
        end
        clx_pkg::CH_TAB, clx_pkg::CH_SPACE: begin
          if (s == clx_pkg::ST_STR || s == clx_pkg::ST_CMT) begin
            mid_v = 1'b1;
          end else begin
            end_sel    = 1'b1;
            state_next = clx_pkg::ST_IDLE;
          end
        end
        clx_pkg::CH_CR, clx_pkg::CH_LF: begin
          end_sel    = 1'b1;
          state_next = clx_pkg::ST_IDLE;
          line_inc   = line_count != {clx_pkg::LineW{1'b1}};
        end
        clx_pkg::CH_QUOTE: begin
          end_sel = 1'b1;
          if (s != clx_pkg::ST_STR) begin
            mid_v      = 1'b1;
            state_next = clx_pkg::ST_STR;
          end else begin
            state_next = clx_pkg::ST_IDLE;
          end
        end
        clx_pkg::CH_BSLASH: begin
          if (s == clx_pkg::ST_STR) begin
            state_next = clx_pkg::ST_ESC;
          end else begin
            end_sel    = 1'b1;
            mid_v      = 1'b1;
            tail_v     = 1'b1;
            state_next = clx_pkg::ST_IDLE;
          end
        end
        clx_pkg::CH_SLASH: begin
          if (s == clx_pkg::ST_STR) begin
            mid_v = 1'b1;
          end else if (s == clx_pkg::ST_SLASH) begin
            tail_v       = 1'b1;
            tail_ev.kind = clx_pkg::KIND_DROP;
            tail_ev.tok  = clx_pkg::TOK_INT;
            state_next   = clx_pkg::ST_CMT;
          end else begin
            end_sel    = 1'b1;
            mid_v      = 1'b1;
            state_next = clx_pkg::ST_SLASH;
          end
        end
        default: begin
          mid_v = 1'b1;
          if (s == clx_pkg::ST_IDLE || s == clx_pkg::ST_INT || s == clx_pkg::ST_DEC) begin
            end_sel    = 1'b1;
            state_next = clx_pkg::ST_IDENT;
          end else if (s == clx_pkg::ST_DOT) begin
            state_next = clx_pkg::ST_DOTMORE;
          end
        end
      endcase
    end
  end

  // pack the events in order
  always_comb begin
    cand   = {tail_ev, mid_ev, end_ev, op_ev};
    cand_v = {tail_v, mid_v, end_sel && end_has, flush};
    grp_ev = '0;
    n      = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        grp_ev[n[clx_pkg::EvIdxW-1:0]] = cand[i];
        n = n + 1'b1;
      end
    end
  end

  assign push         = adv && (n != '0);
  assign grp.ev       = grp_ev;
  assign grp.last_idx = clx_pkg::EvIdxW'(n - 1'b1);
  assign grp.line     = line_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      lex_state  <= clx_pkg::ST_IDLE;
      line_count <= '0;
    end else begin
      if (in_ch.ready) begin
        hold_valid <= in_ch.valid;
      end
      if (adv) begin
        lex_state <= state_next;
        if (line_inc) begin
          line_count <= line_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_ch <= in_ch.ch;
    end
  end

endmodule
`default_nettype wire

// File: rtl/clx_emit.sv
`default_nettype none
// event group queue and one-event-per-transfer output serializer
module clx_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire clx_pkg::group_t   grp,
  output logic                   grp_ready,
  clx_out_if.source              out_ch
);

  clx_pkg::group_t               q [clx_pkg::QDepth];
  logic [clx_pkg::QPtrW-1:0]     wr_ptr;
  logic [clx_pkg::QPtrW-1:0]     rd_ptr;
  logic [clx_pkg::QPtrW:0]       fill;
  logic [clx_pkg::EvIdxW-1:0]    idx;

  clx_pkg::group_t               head;
  clx_pkg::lex_event_t           ev;
  logic                          is_last;
  logic                          xfer;
  logic                          pop;

  assign head      = q[rd_ptr];
  assign ev        = head.ev[idx];
  assign is_last   = idx == head.last_idx;
  assign grp_ready = fill != (clx_pkg::QPtrW + 1)'(clx_pkg::QDepth);
  assign xfer      = out_ch.valid && out_ch.ready;
  assign pop       = xfer && is_last;

  assign out_ch.valid    = fill != '0;
  assign out_ch.kind     = ev.kind;
  assign out_ch.ch_out   = ev.ch;
  assign out_ch.tok_type = ev.tok;
  assign out_ch.line     = head.line;
  assign out_ch.last     = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (xfer) begin
        if (is_last) begin
          idx    <= '0;
          rd_ptr <= rd_ptr + 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= grp;
    end
  end

endmodule
`default_nettype wire

// File: rtl/char_stream_lexer_core.sv
`default_nettype none
// top level of the character stream lexer
// datapath: an accepted character is held in the input register, decoded into an event group and queued
// throughput: one character per cycle while the four-group event queue has room
// output: one event per transfer, so a character with k events takes k transfers on the port
// reset: lexer state to idle, line counter to zero, event queue emptied
module char_stream_lexer_core (
  input  wire logic  clk,
  input  wire logic  rst,
  clx_in_if.sink     in_ch,
  clx_out_if.source  out_ch
);

  logic              push;
  logic              grp_ready;
  clx_pkg::group_t   grp;

  clx_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .grp_ready (grp_ready),
    .push      (push),
    .grp       (grp)
  );

  clx_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
